/* rtl/ism_pkg.sv */
package ism_pkg;

  localparam int WORD_W  = 32;
  localparam int IDX_W   = 16;
  localparam int KIND_W  = 3;
  localparam int DEPTH_W = 7;
  localparam int ERR_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    OP_LOAD_CONST   = 3'd0,
    OP_PUSH_CONST   = 3'd1,
    OP_STORE_GLOBAL = 3'd2,
    OP_PUSH_GLOBAL  = 3'd3,
    OP_ADD          = 3'd4,
    OP_PUSH_FUNC    = 3'd5,
    OP_POP          = 3'd6
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK     = 3'd0,
    ERR_UNDER  = 3'd1,
    ERR_OVER   = 3'd2,
    ERR_CONST  = 3'd3,
    ERR_GLOBAL = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_DOWN = 2'd1,
    SH_UP   = 2'd2,
    SH_LOAD = 2'd3
  } sh_t;

  typedef struct packed {
    sh_t               sh;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

/* rtl/ism_in_if.sv */
interface ism_in_if;
  logic                              valid;
  logic                              ready;
  logic [ism_pkg::KIND_W-1:0]        kind;
  logic [ism_pkg::IDX_W-1:0]         index;
  logic signed [ism_pkg::WORD_W-1:0] value;

  modport source (output valid, kind, index, value, input ready);
  modport sink   (input valid, kind, index, value, output ready);
endinterface

/* rtl/ism_out_if.sv */
interface ism_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ism_pkg::WORD_W-1:0] top_value;
  logic [ism_pkg::DEPTH_W-1:0]       depth;
  logic [ism_pkg::ERR_W-1:0]         error;

  modport source (output valid, top_value, depth, error, input ready);
  modport sink   (input valid, top_value, depth, error, output ready);
endinterface

/* rtl/ism_cell.sv */
module ism_cell (
  input  logic                       clk,
  input  ism_pkg::cell_ctl_t         ctl,
  input  logic [ism_pkg::WORD_W-1:0] down_word,
  input  logic [ism_pkg::WORD_W-1:0] up_word,
  output logic [ism_pkg::WORD_W-1:0] q
);

  logic [ism_pkg::WORD_W-1:0] word_r;
  logic [ism_pkg::WORD_W-1:0] word_nxt;

  always_comb begin
    unique case (ctl.sh)
      ism_pkg::SH_HOLD: word_nxt = word_r;
      ism_pkg::SH_DOWN: word_nxt = down_word;
      ism_pkg::SH_UP:   word_nxt = up_word;
      ism_pkg::SH_LOAD: word_nxt = ctl.word;
      default:          word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

/* rtl/ism_ram.sv */
module ism_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [ism_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [ism_pkg::WORD_W-1:0] rdata
);

  logic [ism_pkg::WORD_W-1:0] mem [DEPTH];
  logic [ism_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/int_stack_machine_core_unit.sv */
// Stack-machine execute unit: one decoded instruction per item, one result item per
// instruction. The operand stack is a row of shift cells with the top in cell 0, so push,
// pop and add each need only a shift of the cells; constants and globals live in memories
// with a registered read. Sustained rate is one item per clock while the output is ready.
// An item is accepted into a holding register while its constant/global read is issued,
// and executes on the next edge that the output register is free; that same edge loads
// its result into the output register. After reset the global store is zeroed by a
// clearing pass over every entry, during which no item is accepted.
module int_stack_machine_core_unit #(
  parameter int STACK_DEPTH  = 64,
  parameter int CONST_DEPTH  = 256,
  parameter int GLOBAL_DEPTH = 256
) (
  input logic     clk,
  input logic     rst_n,
  ism_in_if.sink  in_chan,
  ism_out_if.source out_chan
);

  localparam int WW  = ism_pkg::WORD_W;
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int CAW = (CONST_DEPTH > 1) ? $clog2(CONST_DEPTH) : 1;
  localparam int GAW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;

  // clearing pass
  logic           clr_busy_r;
  logic [GAW-1:0] clr_addr_r;

  // holding stage
  logic                      s1_vld_r;
  ism_pkg::op_t              kind_r;
  logic [ism_pkg::IDX_W-1:0] idx_r;
  logic [WW-1:0]             val_r;
  logic                      c_hit_r;
  logic                      g_hit_r;
  logic [WW-1:0]             c_byp_r;
  logic [WW-1:0]             g_byp_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // output register
  logic                        out_vld_r;
  logic [WW-1:0]               top_r;
  logic [ism_pkg::DEPTH_W-1:0] depth_r;
  ism_pkg::err_t               err_r;

  logic accept;
  logic fire;
  logic in_rdy;

  logic [WW-1:0] cell_q [STACK_DEPTH];
  ism_pkg::cell_ctl_t top_ctl;
  ism_pkg::cell_ctl_t rest_ctl;

  logic           c_we;
  logic [CAW-1:0] c_waddr;
  logic [WW-1:0]  c_rdata;
  logic           g_we;
  logic [GAW-1:0] g_waddr;
  logic [WW-1:0]  g_wdata;
  logic [WW-1:0]  g_rdata;

  logic          c_ok;
  logic          g_ok;
  logic          full;
  logic          empty;
  logic          lt2;
  logic [WW-1:0] c_word;
  logic [WW-1:0] g_word;
  logic [WW-1:0] sum;
  logic [WW-1:0] push_word;
  logic [WW-1:0] top_word;
  logic          do_push;
  logic          do_pop;
  logic          do_add;
  logic          c_st;
  logic          g_st;
  ism_pkg::err_t err;

  assign fire    = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_rdy  = !clr_busy_r && (!s1_vld_r || fire);
  assign accept  = in_chan.valid && in_rdy;
  assign in_chan.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == GAW'(GLOBAL_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + GAW'(1);
    end
  end

  // memories
  assign c_we    = fire && c_st;
  assign c_waddr = idx_r[CAW-1:0];
  assign g_we    = clr_busy_r || (fire && g_st);
  assign g_waddr = clr_busy_r ? clr_addr_r : idx_r[GAW-1:0];
  assign g_wdata = clr_busy_r ? '0 : cell_q[0];

  ism_ram #(.DEPTH(CONST_DEPTH), .AW(CAW)) u_const_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (val_r),
    .re    (accept),
    .raddr (in_chan.index[CAW-1:0]),
    .rdata (c_rdata)
  );

  ism_ram #(.DEPTH(GLOBAL_DEPTH), .AW(GAW)) u_global_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (accept),
    .raddr (in_chan.index[GAW-1:0]),
    .rdata (g_rdata)
  );

  // holding stage; a write on the accept edge is not seen by the read, so forward it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= ism_pkg::op_t'(in_chan.kind);
      idx_r   <= in_chan.index;
      val_r   <= in_chan.value;
      c_hit_r <= c_we && (c_waddr == in_chan.index[CAW-1:0]);
      g_hit_r <= g_we && (g_waddr == in_chan.index[GAW-1:0]);
      c_byp_r <= val_r;
      g_byp_r <= g_wdata;
    end
  end

  // execute
  assign c_ok   = {16'd0, idx_r} < 32'(CONST_DEPTH);
  assign g_ok   = {16'd0, idx_r} < 32'(GLOBAL_DEPTH);
  assign full   = count_r == CW'(STACK_DEPTH);
  assign empty  = count_r == '0;
  assign lt2    = count_r < CW'(2);
  assign c_word = c_hit_r ? c_byp_r : c_rdata;
  assign g_word = g_hit_r ? g_byp_r : g_rdata;
  assign sum    = cell_q[0] + cell_q[1];

  always_comb begin
    err       = ism_pkg::ERR_OK;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    do_add    = 1'b0;
    c_st      = 1'b0;
    g_st      = 1'b0;
    push_word = '0;
    unique case (kind_r)
      ism_pkg::OP_LOAD_CONST: begin
        if (!c_ok) err = ism_pkg::ERR_CONST;
        else c_st = 1'b1;
      end
      ism_pkg::OP_PUSH_CONST: begin
        push_word = c_word;
        if (!c_ok) err = ism_pkg::ERR_CONST;
        else if (full) err = ism_pkg::ERR_OVER;
        else do_push = 1'b1;
      end
      ism_pkg::OP_STORE_GLOBAL: begin
        if (!g_ok) err = ism_pkg::ERR_GLOBAL;
        else if (empty) err = ism_pkg::ERR_UNDER;
        else begin
          g_st   = 1'b1;
          do_pop = 1'b1;
        end
      end
      ism_pkg::OP_PUSH_GLOBAL: begin
        push_word = g_word;
        if (!g_ok) err = ism_pkg::ERR_GLOBAL;
        else if (full) err = ism_pkg::ERR_OVER;
        else do_push = 1'b1;
      end
      ism_pkg::OP_ADD: begin
        if (lt2) err = ism_pkg::ERR_UNDER;
        else do_add = 1'b1;
      end
      ism_pkg::OP_PUSH_FUNC: begin
        push_word = WW'(idx_r);
        if (full) err = ism_pkg::ERR_OVER;
        else do_push = 1'b1;
      end
      ism_pkg::OP_POP: begin
        if (empty) err = ism_pkg::ERR_UNDER;
        else do_pop = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    top_ctl   = '{sh: ism_pkg::SH_HOLD, word: '0};
    rest_ctl  = '{sh: ism_pkg::SH_HOLD, word: '0};
    top_word  = cell_q[0];
    priority if (do_push) begin
      count_nxt   = count_r + CW'(1);
      top_ctl     = '{sh: ism_pkg::SH_LOAD, word: push_word};
      rest_ctl.sh = ism_pkg::SH_DOWN;
      top_word    = push_word;
    end else if (do_add) begin
      count_nxt   = count_r - CW'(1);
      top_ctl     = '{sh: ism_pkg::SH_LOAD, word: sum};
      rest_ctl.sh = ism_pkg::SH_UP;
      top_word    = sum;
    end else if (do_pop) begin
      count_nxt   = count_r - CW'(1);
      top_ctl.sh  = ism_pkg::SH_UP;
      rest_ctl.sh = ism_pkg::SH_UP;
      top_word    = cell_q[1];
    end
  end

  // stack cells, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WW-1:0]      down_w;
    logic [WW-1:0]      up_w;
    ism_pkg::cell_ctl_t ctl_w;

    if (i == 0) begin : g_top
      assign down_w = '0;
      assign ctl_w  = fire ? top_ctl : '{sh: ism_pkg::SH_HOLD, word: '0};
    end else begin : g_rest
      assign down_w = cell_q[i-1];
      assign ctl_w  = fire ? rest_ctl : '{sh: ism_pkg::SH_HOLD, word: '0};
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign up_w = '0;
    end else begin : g_mid
      assign up_w = cell_q[i+1];
    end

    ism_cell u_cell (
      .clk       (clk),
      .ctl       (ctl_w),
      .down_word (down_w),
      .up_word   (up_w),
      .q         (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      top_r   <= (count_nxt == '0) ? '0 : top_word;
      depth_r <= ism_pkg::DEPTH_W'(count_nxt);
      err_r   <= err;
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.top_value = top_r;
  assign out_chan.depth     = depth_r;
  assign out_chan.error     = err_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_rdy)
    else $error("item accepted during global clear");

  a_fault_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (err != ism_pkg::ERR_OK) |=> $stable(count_r))
    else $error("faulting item changed stack count");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("executed item produced no result");

endmodule

/* tb/int_stack_machine_core_unit_tb.sv */
module int_stack_machine_core_unit_tb;

  localparam int STACK_N      = 64;
  localparam int CONST_N      = 256;
  localparam int GLOBAL_N     = 256;
  localparam int RANDOM_ITEMS = 1630;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 5000;

  // kind code with no operation behind it
  localparam logic [ism_pkg::KIND_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [ism_pkg::WORD_W-1:0]  top;
    logic [ism_pkg::DEPTH_W-1:0] depth;
    logic [ism_pkg::ERR_W-1:0]   err;
  } vm_status_t;

  typedef enum int {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} phase_t;

  class vm_status_board;
    logic [ism_pkg::WORD_W-1:0] stack_mem [STACK_N];
    logic [ism_pkg::WORD_W-1:0] const_mem [CONST_N];
    bit                         const_set [CONST_N];
    logic [ism_pkg::WORD_W-1:0] global_mem [GLOBAL_N];
    int unsigned                depth_now;
    int unsigned                peak_depth;
    vm_status_t                 expected_status_q [$];
    int                         fail_count;
    int                         items_seen;
    int                         results_seen;
    int                         err_hits [8];

    function new();
      for (int i = 0; i < GLOBAL_N; i++) global_mem[i] = '0;
      for (int i = 0; i < CONST_N; i++) const_set[i] = 1'b0;
      foreach (err_hits[i]) err_hits[i] = 0;
      depth_now    = 0;
      peak_depth   = 0;
      fail_count   = 0;
      items_seen   = 0;
      results_seen = 0;
    endfunction

    function ism_pkg::err_t push_entry(logic [ism_pkg::WORD_W-1:0] w);
      if (depth_now >= STACK_N) return ism_pkg::ERR_OVER;
      stack_mem[depth_now] = w;
      depth_now++;
      if (depth_now > peak_depth) peak_depth = depth_now;
      return ism_pkg::ERR_OK;
    endfunction

    // works out the status item that one accepted instruction produces
    function void run_instruction(logic [ism_pkg::KIND_W-1:0] kind,
                                  logic [ism_pkg::IDX_W-1:0] idx,
                                  logic [ism_pkg::WORD_W-1:0] val);
      ism_pkg::err_t              e;
      vm_status_t                 s;
      logic [ism_pkg::WORD_W-1:0] sum;
      e = ism_pkg::ERR_OK;
      case (kind)
        ism_pkg::OP_LOAD_CONST: begin
          if (idx >= CONST_N) e = ism_pkg::ERR_CONST;
          else begin
            const_mem[idx] = val;
            const_set[idx] = 1'b1;
          end
        end
        ism_pkg::OP_PUSH_CONST: begin
          if (idx >= CONST_N) e = ism_pkg::ERR_CONST;
          else e = push_entry(const_mem[idx]);
        end
        ism_pkg::OP_STORE_GLOBAL: begin
          if (idx >= GLOBAL_N) e = ism_pkg::ERR_GLOBAL;
          else if (depth_now == 0) e = ism_pkg::ERR_UNDER;
          else begin
            depth_now--;
            global_mem[idx] = stack_mem[depth_now];
          end
        end
        ism_pkg::OP_PUSH_GLOBAL: begin
          if (idx >= GLOBAL_N) e = ism_pkg::ERR_GLOBAL;
          else e = push_entry(global_mem[idx]);
        end
        ism_pkg::OP_ADD: begin
          if (depth_now < 2) e = ism_pkg::ERR_UNDER;
          else begin
            sum = stack_mem[depth_now-1] + stack_mem[depth_now-2];
            depth_now--;
            stack_mem[depth_now-1] = sum;
          end
        end
        ism_pkg::OP_PUSH_FUNC:
          e = push_entry({{(ism_pkg::WORD_W-ism_pkg::IDX_W){1'b0}}, idx});
        ism_pkg::OP_POP: begin
          if (depth_now == 0) e = ism_pkg::ERR_UNDER;
          else depth_now--;
        end
        default: ;
      endcase
      s.top   = (depth_now > 0) ? stack_mem[depth_now-1] : '0;
      s.depth = ism_pkg::DEPTH_W'(depth_now);
      s.err   = e;
      expected_status_q.push_back(s);
      err_hits[e]++;
      items_seen++;
    endfunction

    function void check_result(logic [ism_pkg::WORD_W-1:0] top,
                               logic [ism_pkg::DEPTH_W-1:0] depth,
                               logic [ism_pkg::ERR_W-1:0] err);
      vm_status_t want;
      if (expected_status_q.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing pending: top_value=%h depth=%0d error=%0d",
                 $time, top, depth, err);
        return;
      end
      want = expected_status_q.pop_front();
      results_seen++;
      if (top !== want.top) begin
        fail_count++;
        $display("%0t: top_value expected %h got %h", $time, want.top, top);
      end
      if (depth !== want.depth) begin
        fail_count++;
        $display("%0t: depth expected %0d got %0d", $time, want.depth, depth);
      end
      if (err !== want.err) begin
        fail_count++;
        $display("%0t: error expected %0d got %0d", $time, want.err, err);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ism_in_if  in_ch();
  ism_out_if out_ch();

  int_stack_machine_core_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  vm_status_board board;
  bit             no_idle      = 1'b0;
  int             hold_req_n   = 0;
  int             idle_cycles  = 0;
  phase_t         cur_phase    = MIX_PHASE;

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [ism_pkg::KIND_W-1:0] kind,
                           input logic [ism_pkg::IDX_W-1:0] idx,
                           input logic [ism_pkg::WORD_W-1:0] val);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.index <= idx;
    in_ch.value <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.run_instruction(kind, idx, val);
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and let every pending status item come back
  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.expected_status_q.size() != 0);
  endtask

  task automatic pick_item(output logic [ism_pkg::KIND_W-1:0] kind,
                           output logic [ism_pkg::IDX_W-1:0] idx,
                           output logic [ism_pkg::WORD_W-1:0] val);
    int r;
    r    = $urandom_range(0, 99);
    val  = $urandom();
    idx  = ism_pkg::IDX_W'($urandom_range(0, GLOBAL_N - 1));
    kind = ism_pkg::OP_POP;
    if (r < 8) begin
      // noise: any kind, any index
      kind = ism_pkg::KIND_W'($urandom_range(0, 7));
      idx  = ism_pkg::IDX_W'($urandom());
    end else begin
      r = $urandom_range(0, 99);
      case (cur_phase)
        FILL_PHASE: begin
          if (r < 30)      kind = ism_pkg::OP_PUSH_CONST;
          else if (r < 50) kind = ism_pkg::OP_PUSH_GLOBAL;
          else if (r < 65) kind = ism_pkg::OP_PUSH_FUNC;
          else if (r < 80) kind = ism_pkg::OP_LOAD_CONST;
          else if (r < 90) kind = ism_pkg::OP_ADD;
          else             kind = ism_pkg::OP_POP;
        end
        DRAIN_PHASE: begin
          if (r < 30)      kind = ism_pkg::OP_POP;
          else if (r < 55) kind = ism_pkg::OP_STORE_GLOBAL;
          else if (r < 85) kind = ism_pkg::OP_ADD;
          else if (r < 95) kind = ism_pkg::OP_PUSH_CONST;
          else             kind = ism_pkg::OP_LOAD_CONST;
        end
        default: kind = ism_pkg::KIND_W'($urandom_range(0, 6));
      endcase
      if (kind == ism_pkg::OP_PUSH_FUNC) idx = ism_pkg::IDX_W'($urandom());
      else if ($urandom_range(0, 19) == 0)
        idx = ism_pkg::IDX_W'($urandom_range(CONST_N, 65535));
    end
    // never read a constant entry that has not been written
    if (kind == ism_pkg::OP_PUSH_CONST && idx < CONST_N && !board.const_set[idx])
      kind = ism_pkg::OP_LOAD_CONST;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.top_value, out_ch.depth, out_ch.error);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    int g;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req_n != hold_seen) begin
        stall_left = HOLD_CYCLES;
        hold_seen  = hold_req_n;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        g = no_idle ? 0 : gap_len();
        if (g == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = g - 1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [ism_pkg::KIND_W-1:0] k;
    logic [ism_pkg::IDX_W-1:0]  ix;
    logic [ism_pkg::WORD_W-1:0] v;
    int                         phase_left;
    board = new();
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= ism_pkg::OP_LOAD_CONST;
    in_ch.index <= '0;
    in_ch.value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty-stack faults, index check ahead of the stack check
    send_item(ism_pkg::OP_POP, 16'd0, 32'd0);
    send_item(ism_pkg::OP_ADD, 16'd0, 32'd0);
    send_item(ism_pkg::OP_STORE_GLOBAL, 16'd0, 32'd0);
    send_item(ism_pkg::OP_STORE_GLOBAL, 16'd300, 32'd0);
    // constant store edges and out of range loads
    send_item(ism_pkg::OP_LOAD_CONST, 16'd0, 32'h7fff_ffff);
    send_item(ism_pkg::OP_LOAD_CONST, 16'd255, 32'h8000_0000);
    send_item(ism_pkg::OP_LOAD_CONST, 16'd256, 32'h1234_5678);
    send_item(ism_pkg::OP_LOAD_CONST, 16'hffff, 32'hffff_ffff);
    send_item(ism_pkg::OP_PUSH_CONST, 16'd0, 32'hffff_ffff);
    send_item(ism_pkg::OP_PUSH_CONST, 16'd255, 32'd0);
    send_item(ism_pkg::OP_ADD, 16'hffff, 32'd0);
    send_item(ism_pkg::OP_PUSH_CONST, 16'hffff, 32'd0);
    // globals read back as zero after reset
    send_item(ism_pkg::OP_PUSH_GLOBAL, 16'd255, 32'd0);
    send_item(ism_pkg::OP_PUSH_GLOBAL, 16'd256, 32'd0);
    send_item(ism_pkg::OP_STORE_GLOBAL, 16'hffff, 32'd0);
    send_item(ism_pkg::OP_STORE_GLOBAL, 16'd255, 32'd0);
    send_item(ism_pkg::OP_PUSH_FUNC, 16'hffff, 32'd0);
    send_item(ism_pkg::OP_PUSH_FUNC, 16'd0, 32'd0);
    send_item(OP_UNUSED, 16'hffff, 32'hffff_ffff);
    send_item(ism_pkg::OP_ADD, 16'd0, 32'd0);
    send_item(ism_pkg::OP_POP, 16'd0, 32'd0);
    send_item(ism_pkg::OP_PUSH_GLOBAL, 16'd255, 32'd0);
    send_item(ism_pkg::OP_ADD, 16'd0, 32'd0);
    send_item(ism_pkg::OP_POP, 16'd0, 32'd0);
    drain_wait();

    phase_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 120);
        cur_phase  = phase_t'($urandom_range(0, 2));
        no_idle    = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 5) == 0) drain_wait();
      end
      if (n == RANDOM_ITEMS / 4 || n == 3 * RANDOM_ITEMS / 4) drain_wait();
      // long receiver hold while the sender keeps offering
      if (n == RANDOM_ITEMS / 2) begin
        hold_req_n++;
        no_idle = 1'b1;
      end
      pick_item(k, ix, v);
      send_item(k, ix, v);
      phase_left--;
    end
    drain_wait();
    repeat (8) @(posedge clk);

    $display("covered %0d instructions, %0d status items, peak depth %0d",
             board.items_seen, board.results_seen, board.peak_depth);
    $display("errors seen: underflow %0d, overflow %0d, bad constant %0d, bad global %0d",
             board.err_hits[ism_pkg::ERR_UNDER], board.err_hits[ism_pkg::ERR_OVER],
             board.err_hits[ism_pkg::ERR_CONST], board.err_hits[ism_pkg::ERR_GLOBAL]);
    if (board.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
